// ----- rtl/core/dss_pkg.sv -----
`timescale 1ns / 1ps

package dss_pkg;

    // datapath widths
    localparam int DUTY_BITS = 10;
    localparam int FRAC_BITS = 12;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

    // servo duty per position: pulse 500..2500 us over a 20 ms frame
    localparam int SERVO_D0 = ((500 + (0 * 2000) / 180) * ((1 << DUTY_BITS) - 1)) / 20000;
    localparam int SERVO_D1 = ((500 + (60 * 2000) / 180) * ((1 << DUTY_BITS) - 1)) / 20000;
    localparam int SERVO_D2 = ((500 + (120 * 2000) / 180) * ((1 << DUTY_BITS) - 1)) / 20000;
    localparam int SERVO_D3 = ((500 + (180 * 2000) / 180) * ((1 << DUTY_BITS) - 1)) / 20000;

    // stream payload widths
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_BITS    = 4 * DUTY_BITS + 4 + DUTY_BITS + 3;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_TURN_MS   = 3'd1,
        CFG_DRIVE_MS  = 3'd2,
        CFG_HOLD_MS   = 3'd3,
        CFG_CRUISE    = 3'd4
    } t_cfg_idx;

    // drive modes
    typedef enum logic [2:0] {
        MODE_HOLD     = 3'd0,
        MODE_TURN     = 3'd1,
        MODE_STRAIGHT = 3'd2,
        MODE_SEARCH_L = 3'd3,
        MODE_SEARCH_R = 3'd4,
        MODE_STOPPED  = 3'd5
    } t_mode;

    typedef struct packed {
        logic [15:0]          threshold;
        logic [15:0]          turn_ms;
        logic [15:0]          drive_ms;
        logic [15:0]          hold_ms;
        logic [DUTY_BITS-1:0] cruise;
    } t_cfg;

    typedef struct packed {
        logic [15:0] held_linear;
        logic [15:0] held_angular;
        logic        seq_active;
        logic [31:0] seq_start;
        logic        hold_active;
        logic        stepped;
        logic [31:0] hold_start;
        logic [1:0]  servo_pos;
    } t_state;

    typedef struct packed {
        logic [DUTY_BITS-1:0] fl_duty;
        logic [DUTY_BITS-1:0] rl_duty;
        logic [DUTY_BITS-1:0] fr_duty;
        logic [DUTY_BITS-1:0] rr_duty;
        logic                 fl_dir;
        logic                 rl_dir;
        logic                 fr_dir;
        logic                 rr_dir;
        logic [DUTY_BITS-1:0] servo;
        t_mode                mode;
    } t_result;

    // one run of the sequence start/end rule
    function automatic t_state run_rule(t_state s, t_cfg c, logic [31:0] now);
        t_state      r;
        logic [16:0] total;
        logic [31:0] elapsed;
        r = s;
        total = {1'b0, c.turn_ms} + {1'b0, c.drive_ms};
        if ($signed(r.held_linear) > $signed(c.threshold) && !r.seq_active) begin
            r.seq_active = 1'b1;
            r.seq_start  = now;
            r.stepped    = 1'b0;
        end
        elapsed = now - r.seq_start;
        if (r.seq_active && elapsed >= {15'd0, total}) begin
            r.seq_active = 1'b0;
            if (!r.stepped) begin
                r.servo_pos   = (r.servo_pos == 2'd3) ? 2'd1 : r.servo_pos + 2'd1;
                r.hold_active = 1'b1;
                r.hold_start  = now;
                r.stepped     = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [DUTY_BITS-1:0] servo_duty_of(logic [1:0] pos);
        logic [DUTY_BITS-1:0] d;
        case (pos)
            2'd0:    d = DUTY_BITS'(SERVO_D0);
            2'd1:    d = DUTY_BITS'(SERVO_D1);
            2'd2:    d = DUTY_BITS'(SERVO_D2);
            default: d = DUTY_BITS'(SERVO_D3);
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/core/dss_step.sv -----
`timescale 1ns / 1ps

module dss_step (
    input  dss_pkg::t_state  i_state,
    input  dss_pkg::t_cfg    i_cfg,
    input  logic             i_command_valid,
    input  logic [15:0]      i_lin_cmd,
    input  logic [15:0]      i_ang_cmd,
    input  logic [31:0]      i_now_ms,
    output dss_pkg::t_state  o_state,
    output dss_pkg::t_result o_result
);

    dss_pkg::t_state s_cmd;
    dss_pkg::t_state s_rule;
    dss_pkg::t_state s_next;
    logic [31:0]     hold_elapsed;
    logic [31:0]     seq_elapsed;
    logic [dss_pkg::FRAC_BITS-1:0] ang_frac;
    logic [dss_pkg::FRAC_BITS+dss_pkg::DUTY_BITS-1:0] search_prod;
    logic [dss_pkg::DUTY_BITS-1:0] search_duty;
    logic [dss_pkg::DUTY_BITS-1:0] cd;

    // latch new command and run the rule an extra time on command passes
    always_comb begin
        s_cmd = i_state;
        if (i_command_valid) begin
            s_cmd.held_linear  = i_lin_cmd;
            s_cmd.held_angular = i_ang_cmd;
            s_cmd = dss_pkg::run_rule(s_cmd, i_cfg, i_now_ms);
        end
        s_rule = dss_pkg::run_rule(s_cmd, i_cfg, i_now_ms);
    end

    // servo hold expiry
    assign hold_elapsed = i_now_ms - s_rule.hold_start;
    always_comb begin
        s_next = s_rule;
        if (s_rule.hold_active && hold_elapsed >= {16'd0, i_cfg.hold_ms}) begin
            s_next.hold_active = 1'b0;
        end
    end
    assign o_state = s_next;

    // search-left duty: min(angular, 1.0) scaled to full duty
    assign ang_frac    = s_next.held_angular[dss_pkg::FRAC_BITS-1:0];
    assign search_prod = ang_frac * dss_pkg::DUTY_MAX;
    assign search_duty = (s_next.held_angular[14:dss_pkg::FRAC_BITS] != '0)
        ? dss_pkg::DUTY_MAX
        : search_prod[dss_pkg::FRAC_BITS+dss_pkg::DUTY_BITS-1:dss_pkg::FRAC_BITS];

    assign seq_elapsed = i_now_ms - s_next.seq_start;
    assign cd = i_cfg.cruise;

    // wheel selection by mode
    always_comb begin
        o_result = '0;
        o_result.servo = dss_pkg::servo_duty_of(s_next.servo_pos);
        if (s_next.hold_active) begin
            {o_result.fl_dir, o_result.rl_dir, o_result.fr_dir, o_result.rr_dir} = 4'b1111;
            o_result.mode = dss_pkg::MODE_HOLD;
        end else if (s_next.seq_active) begin
            if (seq_elapsed < {16'd0, i_cfg.turn_ms}) begin
                o_result.rl_duty = cd;
                o_result.fr_duty = cd;
                o_result.mode    = dss_pkg::MODE_TURN;
            end else begin
                o_result.fl_duty = cd;
                o_result.rl_duty = cd;
                o_result.fr_duty = cd;
                o_result.rr_duty = cd;
                o_result.fl_dir  = 1'b1;
                o_result.rl_dir  = 1'b1;
                o_result.mode    = dss_pkg::MODE_STRAIGHT;
            end
        end else if (!s_next.held_angular[15] && s_next.held_angular != '0) begin
            o_result.fl_duty = search_duty;
            o_result.rl_duty = search_duty;
            o_result.fr_duty = search_duty;
            o_result.rr_duty = search_duty;
            o_result.fr_dir  = 1'b1;
            o_result.rr_dir  = 1'b1;
            o_result.mode    = dss_pkg::MODE_SEARCH_L;
        end else if (s_next.held_angular[15]) begin
            o_result.rl_duty = cd;
            o_result.fr_duty = cd;
            {o_result.fl_dir, o_result.rl_dir, o_result.fr_dir, o_result.rr_dir} = 4'b1111;
            o_result.mode    = dss_pkg::MODE_SEARCH_R;
        end else begin
            {o_result.fl_dir, o_result.rl_dir, o_result.fr_dir, o_result.rr_dir} = 4'b1111;
            o_result.mode    = dss_pkg::MODE_STOPPED;
        end
    end

endmodule

// ----- rtl/core/drive_and_servo_sequencer.sv -----
`timescale 1ns / 1ps

// Drive and servo sequencer.
// Input stream: one transfer per control pass. tdata carries the linear and
// angular commands (Q4.12) and the millisecond timestamp; tuser says a new
// command comes with this pass. Output stream: one transfer per pass with four
// wheel duties, four direction levels, the servo duty and the drive mode.
// Configuration: write enable, register index and 16-bit data, taken at any
// clock edge with the enable high; write only while no pass is in flight.
// The result passes the input register, then the result register behind the
// combinational sequence and wheel logic.
// Throughput: one pass per clock while the receiver takes results; the whole
// state update is done combinationally by the sequence logic, so passes
// follow back to back.
// When the receiver stalls, the result register holds and the input register
// fills; input tready drops only once both are full.
// Reset (synchronous, active low) empties the pipeline, restores the register
// defaults, ends any sequence or hold, and puts the servo at 0 degrees.
module drive_and_servo_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // linear command, angular command, now_ms
    input  logic [dss_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // command_valid
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // front_left_duty, rear_left_duty, front_right_duty, rear_right_duty,
    // front_left_dir, rear_left_dir, front_right_dir, rear_right_dir,
    // servo_duty, drive_mode, zero pad
    output logic [dss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [dss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    dss_pkg::t_cfg    r_cfg;
    dss_pkg::t_state  r_state;
    dss_pkg::t_state  n_state;
    dss_pkg::t_result n_result;
    dss_pkg::t_result r_result;
    logic             r_in_valid;
    logic             r_cmd;
    logic [dss_pkg::IN_TDATA_W-1:0] r_in_data;
    logic             r_out_valid;
    logic             advance;

    // pipeline handshake
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= 16'd409;
            r_cfg.turn_ms   <= 16'd1500;
            r_cfg.drive_ms  <= 16'd3000;
            r_cfg.hold_ms   <= 16'd1000;
            r_cfg.cruise    <= dss_pkg::DUTY_BITS'(511);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dss_pkg::CFG_THRESHOLD: r_cfg.threshold <= i_cfg_data;
                dss_pkg::CFG_TURN_MS:   r_cfg.turn_ms   <= i_cfg_data;
                dss_pkg::CFG_DRIVE_MS:  r_cfg.drive_ms  <= i_cfg_data;
                dss_pkg::CFG_HOLD_MS:   r_cfg.hold_ms   <= i_cfg_data;
                dss_pkg::CFG_CRUISE:    r_cfg.cruise    <= i_cfg_data[dss_pkg::DUTY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd     <= s_axis_tuser;
            r_in_data <= s_axis_tdata;
        end
    end

    // sequence and wheel logic
    dss_step u_step (
        .i_state         (r_state),
        .i_cfg           (r_cfg),
        .i_command_valid (r_cmd),
        .i_lin_cmd       (r_in_data[15:0]),
        .i_ang_cmd       (r_in_data[31:16]),
        .i_now_ms        (r_in_data[63:32]),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tdata = {
        (dss_pkg::OUT_TDATA_W - dss_pkg::OUT_BITS)'(0),
        r_result.mode,
        r_result.servo,
        r_result.rr_dir,
        r_result.fr_dir,
        r_result.rl_dir,
        r_result.fl_dir,
        r_result.rr_duty,
        r_result.fr_duty,
        r_result.rl_duty,
        r_result.fl_duty
    };

endmodule
